### rtl/udpa_pkg.sv
// Shared types and constants for the UDP probe ack parser.
// Holds the channel word structs, the status codes and the frame summary.
// No dependencies.
package udpa_pkg;

    // Default number of frame bytes that are captured; later bytes are counted out.
    localparam int unsigned CAPTURE_LIMIT_DEF = 8192;

    localparam logic [15:0] ETHTYPE_IPV4 = 16'h0800;
    localparam logic [3:0]  IP_VERSION_4 = 4'd4;
    localparam logic [3:0]  IP_MIN_WORDS = 4'd5;
    localparam logic [7:0]  PROTO_UDP    = 8'd17;
    localparam logic [7:0]  KIND_DATA    = 8'h30;
    localparam logic [7:0]  KIND_ACK     = 8'h31;

    // Frame offsets and length bounds, in bytes.
    localparam logic [15:0] POS_ETYPE_HI = 16'd12;
    localparam logic [15:0] POS_ETYPE_LO = 16'd13;
    localparam logic [15:0] POS_IP_VHL   = 16'd14;
    localparam logic [15:0] POS_IP_PROTO = 16'd23;
    localparam logic [16:0] ETH_HDR_LEN  = 17'd14;
    localparam logic [16:0] ETH_IP_MIN   = 17'd34;
    localparam logic [16:0] PAY_BASE     = 17'd22;  // Ethernet plus UDP header
    localparam logic [16:0] PAY_END_BASE = 17'd37;  // plus the 15-byte minimum payload

    // Exact division of a 20-bit microsecond count by 1000: (x * RECIP) >> SHIFT.
    localparam int unsigned USEC_SHIFT = 30;
    localparam logic [20:0] USEC_RECIP = 21'd1073742;

    typedef enum logic [3:0] {
        ST_ACK          = 4'd0,
        ST_ACK_IGNORED  = 4'd1,
        ST_UNKNOWN_KIND = 4'd2,
        ST_SHORT_ETH    = 4'd3,
        ST_BAD_ETYPE    = 4'd4,
        ST_SHORT_IP     = 4'd5,
        ST_BAD_VERSION  = 4'd6,
        ST_BAD_IHL      = 4'd7,
        ST_NOT_UDP      = 4'd8,
        ST_SHORT_UDP    = 4'd9,
        ST_SHORT_PAY    = 4'd10
    } t_status;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [31:0] time_sec;
        logic [19:0] time_usec;
    } t_in_word;

    typedef struct packed {
        t_status            status;
        logic [15:0]        tag_first;
        logic [15:0]        tag_second;
        logic [15:0]        tag_third;
        logic [63:0]        send_time_ms;
        logic [63:0]        recv_time_ms;
        logic signed [63:0] delay_ms;
    } t_out_word;

    // Everything captured from one frame, handed over with its last byte.
    typedef struct packed {
        logic [15:0] len;
        logic [15:0] ether_kind;
        logic [3:0]  ip_version;
        logic [3:0]  ip_header_words;
        logic [7:0]  ip_proto;
        logic [7:0]  payload_kind;
        logic [15:0] tag_first;
        logic [15:0] tag_second;
        logic [15:0] tag_third;
        logic [63:0] sent_stamp;
        logic [31:0] time_sec;
        logic [19:0] time_usec;
    } t_frame;

endpackage

### rtl/udpa_capture.sv
// Byte capture for the UDP probe ack parser: counts frame bytes and picks
// header and payload fields out of the byte stream. Depends on udpa_pkg.
module udpa_capture #(
    parameter int unsigned CAPTURE_LIMIT = udpa_pkg::CAPTURE_LIMIT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  udpa_pkg::t_in_word i_word,
    output logic              o_frame_valid,
    output udpa_pkg::t_frame  o_frame
);

    logic [15:0] r_byte_index, n_byte_index;
    logic [15:0] r_ether_kind, n_ether_kind;
    logic [3:0]  r_ip_version, n_ip_version;
    logic [3:0]  r_ip_header_words, n_ip_header_words;
    logic [7:0]  r_ip_proto, n_ip_proto;
    logic [7:0]  r_payload_kind, n_payload_kind;
    logic [15:0] r_tag_first, n_tag_first;
    logic [15:0] r_tag_second, n_tag_second;
    logic [15:0] r_tag_third, n_tag_third;
    logic [63:0] r_sent_stamp, n_sent_stamp;

    logic [16:0] w_pay_start;
    logic [16:0] w_off;
    logic [7:0]  w_b;
    logic        w_in_window;

    assign w_b         = i_word.data_byte;
    assign w_pay_start = udpa_pkg::PAY_BASE + {11'd0, r_ip_header_words, 2'b00};
    assign w_off       = {1'b0, r_byte_index} - w_pay_start;
    assign w_in_window = r_byte_index < 16'(CAPTURE_LIMIT);

    always_comb begin
        n_byte_index      = r_byte_index;
        n_ether_kind      = r_ether_kind;
        n_ip_version      = r_ip_version;
        n_ip_header_words = r_ip_header_words;
        n_ip_proto        = r_ip_proto;
        n_payload_kind    = r_payload_kind;
        n_tag_first       = r_tag_first;
        n_tag_second      = r_tag_second;
        n_tag_third       = r_tag_third;
        n_sent_stamp      = r_sent_stamp;
        if (w_in_window) begin
            n_byte_index = r_byte_index + 16'd1;
            if (r_byte_index == udpa_pkg::POS_ETYPE_HI) begin
                n_ether_kind[15:8] = w_b;
            end
            if (r_byte_index == udpa_pkg::POS_ETYPE_LO) begin
                n_ether_kind[7:0] = w_b;
            end
            if (r_byte_index == udpa_pkg::POS_IP_VHL) begin
                n_ip_version      = w_b[7:4];
                n_ip_header_words = w_b[3:0];
            end else begin
                if (r_byte_index == udpa_pkg::POS_IP_PROTO) begin
                    n_ip_proto = w_b;
                end
                // Payload bytes sit at offsets set by the IP header length.
                if ({1'b0, r_byte_index} >= w_pay_start && w_off < 17'd15) begin
                    unique case (w_off[3:0])
                        4'd0:    n_payload_kind     = w_b;
                        4'd1:    n_tag_first[15:8]  = w_b;
                        4'd2:    n_tag_first[7:0]   = w_b;
                        4'd3:    n_tag_second[15:8] = w_b;
                        4'd4:    n_tag_second[7:0]  = w_b;
                        4'd5:    n_tag_third[15:8]  = w_b;
                        4'd6:    n_tag_third[7:0]   = w_b;
                        default: n_sent_stamp[8 * (3'(w_off[3:0] - 4'd7)) +: 8] = w_b;
                    endcase
                end
            end
        end
    end

    always_comb begin
        o_frame_valid             = i_accept && i_word.last_byte;
        o_frame.len               = n_byte_index;
        o_frame.ether_kind        = n_ether_kind;
        o_frame.ip_version        = n_ip_version;
        o_frame.ip_header_words   = n_ip_header_words;
        o_frame.ip_proto          = n_ip_proto;
        o_frame.payload_kind      = n_payload_kind;
        o_frame.tag_first         = n_tag_first;
        o_frame.tag_second        = n_tag_second;
        o_frame.tag_third         = n_tag_third;
        o_frame.sent_stamp        = n_sent_stamp;
        o_frame.time_sec          = i_word.time_sec;
        o_frame.time_usec         = i_word.time_usec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_word.last_byte)) begin
            r_byte_index      <= '0;
            r_ether_kind      <= '0;
            r_ip_version      <= '0;
            r_ip_header_words <= '0;
            r_ip_proto        <= '0;
            r_payload_kind    <= '0;
            r_tag_first       <= '0;
            r_tag_second      <= '0;
            r_tag_third       <= '0;
            r_sent_stamp      <= '0;
        end else if (i_accept) begin
            r_byte_index      <= n_byte_index;
            r_ether_kind      <= n_ether_kind;
            r_ip_version      <= n_ip_version;
            r_ip_header_words <= n_ip_header_words;
            r_ip_proto        <= n_ip_proto;
            r_payload_kind    <= n_payload_kind;
            r_tag_first       <= n_tag_first;
            r_tag_second      <= n_tag_second;
            r_tag_third       <= n_tag_third;
            r_sent_stamp      <= n_sent_stamp;
        end
    end

    // The byte count saturates at the capture limit.
    a_index_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_index <= 16'(CAPTURE_LIMIT))
        else $error("byte count passed the capture limit");

    // A last byte starts the next frame from a clean state.
    a_frame_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_word.last_byte) |=>
            (r_byte_index == 16'd0 && r_ip_header_words == 4'd0 && r_sent_stamp == 64'd0))
        else $error("frame state not cleared after last byte");

    // Inside the capture window every accepted middle byte advances the count by one.
    a_index_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !i_word.last_byte && w_in_window) |=>
            (r_byte_index == $past(r_byte_index) + 16'd1))
        else $error("byte count did not advance");

endmodule

### rtl/udpa_result.sv
// Result pipeline for the UDP probe ack parser: judges a finished frame and
// forms the receive time and delay over three register stages. Depends on udpa_pkg.
module udpa_result (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_frame_valid,
    input  udpa_pkg::t_frame  i_frame,
    output logic              o_ready,
    output logic              o_out_valid,
    output udpa_pkg::t_out_word o_out_word,
    input  logic              i_out_stall
);

    // Stage one: the captured frame.
    logic              r_s1_valid;
    udpa_pkg::t_frame  r_s1;

    // Stage two: status, and the time terms.
    logic              r_s2_valid;
    udpa_pkg::t_status r_s2_status;
    logic [15:0]       r_s2_tag_first, r_s2_tag_second, r_s2_tag_third;
    logic [63:0]       r_s2_stamp;
    logic [41:0]       r_s2_sec_ms;
    logic [10:0]       r_s2_usec_ms;

    // Stage three: receive time.
    logic              r_s3_valid;
    udpa_pkg::t_status r_s3_status;
    logic [15:0]       r_s3_tag_first, r_s3_tag_second, r_s3_tag_third;
    logic [63:0]       r_s3_stamp;
    logic [63:0]       r_s3_recv;

    logic              r_out_valid;
    udpa_pkg::t_out_word r_out;

    logic w_out_ready, w_s3_ready, w_s2_ready, w_s1_ready;

    udpa_pkg::t_status w_status;
    logic [16:0]       w_hdr;
    logic [41:0]       w_sec_ms;
    logic [40:0]       w_usec_prod;
    udpa_pkg::t_out_word n_out;

    assign w_out_ready = !r_out_valid || !i_out_stall;
    assign w_s3_ready  = !r_s3_valid || w_out_ready;
    assign w_s2_ready  = !r_s2_valid || w_s3_ready;
    assign w_s1_ready  = !r_s1_valid || w_s2_ready;
    assign o_ready     = w_s1_ready;

    assign w_hdr = {11'd0, r_s1.ip_header_words, 2'b00};

    always_comb begin
        priority if ({1'b0, r_s1.len} < udpa_pkg::ETH_HDR_LEN) begin
            w_status = udpa_pkg::ST_SHORT_ETH;
        end else if (r_s1.ether_kind != udpa_pkg::ETHTYPE_IPV4) begin
            w_status = udpa_pkg::ST_BAD_ETYPE;
        end else if ({1'b0, r_s1.len} < udpa_pkg::ETH_IP_MIN) begin
            w_status = udpa_pkg::ST_SHORT_IP;
        end else if (r_s1.ip_version != udpa_pkg::IP_VERSION_4) begin
            w_status = udpa_pkg::ST_BAD_VERSION;
        end else if (r_s1.ip_header_words < udpa_pkg::IP_MIN_WORDS) begin
            w_status = udpa_pkg::ST_BAD_IHL;
        end else if (r_s1.ip_proto != udpa_pkg::PROTO_UDP) begin
            w_status = udpa_pkg::ST_NOT_UDP;
        end else if ({1'b0, r_s1.len} < udpa_pkg::PAY_BASE + w_hdr) begin
            w_status = udpa_pkg::ST_SHORT_UDP;
        end else if ({1'b0, r_s1.len} < udpa_pkg::PAY_END_BASE + w_hdr) begin
            w_status = udpa_pkg::ST_SHORT_PAY;
        end else if (r_s1.payload_kind == udpa_pkg::KIND_DATA) begin
            w_status = udpa_pkg::ST_ACK;
        end else if (r_s1.payload_kind == udpa_pkg::KIND_ACK) begin
            w_status = udpa_pkg::ST_ACK_IGNORED;
        end else begin
            w_status = udpa_pkg::ST_UNKNOWN_KIND;
        end
    end

    // Seconds times 1000 as 1024 - 16 - 8; microseconds over 1000 by reciprocal.
    assign w_sec_ms    = ({10'd0, r_s1.time_sec} << 10) - ({10'd0, r_s1.time_sec} << 4)
                         - ({10'd0, r_s1.time_sec} << 3);
    assign w_usec_prod = 41'(r_s1.time_usec) * 41'(udpa_pkg::USEC_RECIP);

    always_comb begin
        n_out = '0;
        n_out.status = r_s3_status;
        if (r_s3_status == udpa_pkg::ST_ACK) begin
            n_out.tag_first    = r_s3_tag_first;
            n_out.tag_second   = r_s3_tag_second;
            n_out.tag_third    = r_s3_tag_third;
            n_out.send_time_ms = r_s3_stamp;
            n_out.recv_time_ms = r_s3_recv;
            n_out.delay_ms     = $signed(r_s3_recv - r_s3_stamp);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s1_ready) begin
                r_s1_valid <= i_frame_valid;
            end
            if (w_s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
            if (w_s3_ready) begin
                r_s3_valid <= r_s2_valid;
            end
            if (w_out_ready) begin
                r_out_valid <= r_s3_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_ready && i_frame_valid) begin
            r_s1 <= i_frame;
        end
        if (w_s2_ready && r_s1_valid) begin
            r_s2_status     <= w_status;
            r_s2_tag_first  <= r_s1.tag_first;
            r_s2_tag_second <= r_s1.tag_second;
            r_s2_tag_third  <= r_s1.tag_third;
            r_s2_stamp      <= r_s1.sent_stamp;
            r_s2_sec_ms     <= w_sec_ms;
            r_s2_usec_ms    <= w_usec_prod[40:udpa_pkg::USEC_SHIFT];
        end
        if (w_s3_ready && r_s2_valid) begin
            r_s3_status     <= r_s2_status;
            r_s3_tag_first  <= r_s2_tag_first;
            r_s3_tag_second <= r_s2_tag_second;
            r_s3_tag_third  <= r_s2_tag_third;
            r_s3_stamp      <= r_s2_stamp;
            r_s3_recv       <= 64'(r_s2_sec_ms) + 64'(r_s2_usec_ms);
        end
        if (w_out_ready && r_s3_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // Only an acknowledged data probe carries fields beyond the status.
    a_error_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != udpa_pkg::ST_ACK) |->
            (r_out.tag_first == 16'd0 && r_out.tag_second == 16'd0 &&
             r_out.tag_third == 16'd0 && r_out.send_time_ms == 64'd0 &&
             r_out.recv_time_ms == 64'd0 && r_out.delay_ms == 64'sd0))
        else $error("error result carries nonzero fields");

    // The delay is the wrapped difference of the two times.
    a_delay_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |->
            (64'(r_out.delay_ms) == r_out.recv_time_ms - r_out.send_time_ms))
        else $error("delay does not match receive minus send");

    // The byte side is held back only when every stage holds a result.
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_s1_ready |-> (r_s1_valid && r_s2_valid && r_s3_valid && r_out_valid))
        else $error("input held back with a free stage");

endmodule

### rtl/udp_probe_ack_parser_top.sv
// Top level of the UDP probe ack parser: byte capture feeding the result pipeline.
// Depends on udpa_pkg, udpa_capture and udpa_result.
//
// Usage: frame bytes enter in wire order on the input channel, one word per byte,
// with last_byte set on the final captured byte and the capture timestamp sampled
// with that byte. A word is taken at a rising edge where i_in_valid is high and
// o_in_stall is low; one word can be taken in every cycle. Bytes that are not last
// produce nothing. Each last byte produces exactly one result word on the output
// channel, with a status code and, for an acknowledged data probe, the three tags,
// the send time, the receive time in milliseconds and the wrapped delay.
// The last byte's frame passes in order through the registers of the result
// pipeline (captured frame, status and time terms, receive time sum, delay and
// output register) before the result word appears; an output stall can hold it.
// Throughput: one byte per cycle while o_in_stall is low. When the receiver holds
// i_out_stall high the result pipeline keeps filling; o_in_stall rises only when
// all four result slots hold a frame result, which takes four stalled frames.
// Reset (i_rst_n low at a clock edge) clears the frame state, the byte count and
// every pipeline valid bit, so a new frame starts at its first byte.
// Only the first CAPTURE_LIMIT bytes of a frame are captured; the count holds there.
module udp_probe_ack_parser_top #(
    parameter int unsigned CAPTURE_LIMIT = udpa_pkg::CAPTURE_LIMIT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  udpa_pkg::t_in_word  i_in_word,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output udpa_pkg::t_out_word o_out_word,
    input  logic                i_out_stall
);

    logic             w_accept;
    logic             w_ready;
    logic             w_frame_valid;
    udpa_pkg::t_frame w_frame;

    // The result pipeline decides whether a byte can be taken; a middle byte
    // would not need a slot, but the stall stays independent of the payload.
    assign o_in_stall = !w_ready;
    assign w_accept   = i_in_valid && w_ready;

    udpa_capture #(
        .CAPTURE_LIMIT(CAPTURE_LIMIT)
    ) u_capture (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_word        (i_in_word),
        .o_frame_valid (w_frame_valid),
        .o_frame       (w_frame)
    );

    udpa_result u_result (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame_valid (w_frame_valid),
        .i_frame       (w_frame),
        .o_ready       (w_ready),
        .o_out_valid   (o_out_valid),
        .o_out_word    (o_out_word),
        .i_out_stall   (i_out_stall)
    );

endmodule
